[rtl/alsr_pkg.sv]
// ----------------------------------------------------------------------------
// alsr_pkg: shared types and constants of the LED bit serializer
// Holds the item structs, the configuration bundle, the phase codes and the
// register map that both the register file and the top level use.
// ----------------------------------------------------------------------------
package alsr_pkg;

  // Configuration address width and register indexes (byte address 4*i).
  localparam int unsigned AddrW = 5;
  localparam logic [2:0] RegZeroHigh   = 3'd0;
  localparam logic [2:0] RegZeroPeriod = 3'd1;
  localparam logic [2:0] RegOneHigh    = 3'd2;
  localparam logic [2:0] RegOnePeriod  = 3'd3;
  localparam logic [2:0] RegLatch      = 3'd4;

  // Register reset values.
  localparam logic [11:0] ZeroHighRst   = 12'd35;
  localparam logic [11:0] ZeroPeriodRst = 12'd125;
  localparam logic [11:0] OneHighRst    = 12'd80;
  localparam logic [11:0] OnePeriodRst  = 12'd125;
  localparam logic [19:0] LatchRst      = 20'd30000;

  // Bits in one GRB pixel.
  localparam logic [4:0] PixelBits = 5'd24;

  // Serializer phase.
  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhSend  = 2'd1,
    PhLatch = 2'd2
  } alsr_phase_e;

  // Input item: one clock tick of the waveform, optionally offering a pixel.
  typedef struct packed {
    logic       mode;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic       last_pixel;
  } alsr_in_t;

  // Result item: the line level and status of that tick.
  typedef struct packed {
    logic line_level;
    logic accepted;
    logic can_accept;
    logic busy_res;
    logic frame_done;
    logic underrun;
  } alsr_out_t;

  // Timing configuration handed from the register file to the datapath.
  typedef struct packed {
    logic [11:0] zero_high_cycles;
    logic [11:0] zero_period_cycles;
    logic [11:0] one_high_cycles;
    logic [11:0] one_period_cycles;
    logic [19:0] latch_cycles;
  } alsr_cfg_t;

endpackage

[rtl/alsr_regs.sv]
// ----------------------------------------------------------------------------
// alsr_regs: APB configuration registers of the LED bit serializer
// Five timing registers at byte addresses 0, 4, 8, 12 and 16. Writes are
// registered at the end of the access cycle; reads return the stored value.
// ----------------------------------------------------------------------------
module alsr_regs
  import alsr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output alsr_cfg_t        cfg_o
);

  alsr_cfg_t  cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_high_cycles   <= ZeroHighRst;
      cfg_q.zero_period_cycles <= ZeroPeriodRst;
      cfg_q.one_high_cycles    <= OneHighRst;
      cfg_q.one_period_cycles  <= OnePeriodRst;
      cfg_q.latch_cycles       <= LatchRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegZeroHigh:   cfg_q.zero_high_cycles   <= pwdata[11:0];
        RegZeroPeriod: cfg_q.zero_period_cycles <= pwdata[11:0];
        RegOneHigh:    cfg_q.one_high_cycles    <= pwdata[11:0];
        RegOnePeriod:  cfg_q.one_period_cycles  <= pwdata[11:0];
        RegLatch:      cfg_q.latch_cycles       <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_idx)
      RegZeroHigh:   prdata = {20'd0, cfg_q.zero_high_cycles};
      RegZeroPeriod: prdata = {20'd0, cfg_q.zero_period_cycles};
      RegOneHigh:    prdata = {20'd0, cfg_q.one_high_cycles};
      RegOnePeriod:  prdata = {20'd0, cfg_q.one_period_cycles};
      RegLatch:      prdata = {12'd0, cfg_q.latch_cycles};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/addressable_led_bit_serializer.sv]
// ----------------------------------------------------------------------------
// addressable_led_bit_serializer: one-wire RGB LED chain serializer
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle while out_ready_i is high, set by the single state update per tick.
// Reset clears the phase, counters and pending slot; timing regs take defaults.
// ----------------------------------------------------------------------------
module addressable_led_bit_serializer
  import alsr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Tick and pixel items
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  alsr_in_t         in_data_i,
  // Result items
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output alsr_out_t        out_data_o,
  // Configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  alsr_cfg_t cfg;

  alsr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Serializer state.
  alsr_phase_e phase_q, phase_d;
  logic [23:0] shift_word_q, shift_word_d;
  logic [4:0]  bits_left_q, bits_left_d;
  logic [11:0] bit_cycle_q, bit_cycle_d;
  logic        cur_last_q, cur_last_d;
  logic [23:0] pend_word_q, pend_word_d;
  logic        pend_valid_q, pend_valid_d;
  logic        pend_last_q, pend_last_d;
  logic [19:0] latch_cnt_q, latch_cnt_d;

  // Result register.
  logic      out_valid_q;
  alsr_out_t out_data_q;
  alsr_out_t res;
  logic      in_fire;

  logic        bit_one;
  logic [11:0] high_cnt;
  logic [11:0] period_cnt;
  logic [11:0] bit_cycle_inc;
  logic [19:0] latch_cnt_inc;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // One tick of the serializer: take an offered pixel, then run the phase.
  always_comb begin
    phase_d      = phase_q;
    shift_word_d = shift_word_q;
    bits_left_d  = bits_left_q;
    bit_cycle_d  = bit_cycle_q;
    cur_last_d   = cur_last_q;
    pend_word_d  = pend_word_q;
    pend_valid_d = pend_valid_q;
    pend_last_d  = pend_last_q;
    latch_cnt_d  = latch_cnt_q;
    res          = '0;
    bit_one      = 1'b0;
    high_cnt     = '0;
    period_cnt   = '0;
    bit_cycle_inc = '0;
    latch_cnt_inc = '0;

    // Pending slot fill.
    if (in_data_i.mode && !pend_valid_d) begin
      pend_word_d  = {in_data_i.green, in_data_i.red, in_data_i.blue};
      pend_last_d  = in_data_i.last_pixel;
      pend_valid_d = 1'b1;
      res.accepted = 1'b1;
    end

    // Idle picks up a pending pixel and sends its first tick at once.
    if (phase_d != PhSend && phase_d != PhLatch) begin
      phase_d = PhIdle;
      if (pend_valid_d) begin
        shift_word_d = pend_word_d;
        cur_last_d   = pend_last_d;
        pend_valid_d = 1'b0;
        bits_left_d  = PixelBits;
        bit_cycle_d  = '0;
        phase_d      = PhSend;
      end
    end

    case (phase_d)
      PhSend: begin
        bit_one        = shift_word_d[23];
        high_cnt       = bit_one ? cfg.one_high_cycles : cfg.zero_high_cycles;
        period_cnt     = bit_one ? cfg.one_period_cycles : cfg.zero_period_cycles;
        res.busy_res   = 1'b1;
        res.line_level = (bit_cycle_d < high_cnt);
        bit_cycle_inc  = bit_cycle_d + 12'd1;
        bit_cycle_d    = bit_cycle_inc;
        // End of bit: shift, and at the end of the pixel chain or latch.
        if (bit_cycle_inc >= period_cnt || bit_cycle_inc == 12'd0) begin
          bit_cycle_d  = '0;
          shift_word_d = {shift_word_d[22:0], 1'b0};
          bits_left_d  = bits_left_d - 5'd1;
          if (bits_left_d == 5'd0) begin
            if (cur_last_d) begin
              phase_d     = PhLatch;
              latch_cnt_d = '0;
            end else if (pend_valid_d) begin
              shift_word_d = pend_word_d;
              cur_last_d   = pend_last_d;
              pend_valid_d = 1'b0;
              bits_left_d  = PixelBits;
              bit_cycle_d  = '0;
              phase_d      = PhSend;
            end else begin
              res.underrun = 1'b1;
              phase_d      = PhLatch;
              latch_cnt_d  = '0;
            end
          end
        end
      end
      PhLatch: begin
        res.busy_res  = 1'b1;
        latch_cnt_inc = latch_cnt_d + 20'd1;
        latch_cnt_d   = latch_cnt_inc;
        if (latch_cnt_inc >= cfg.latch_cycles || latch_cnt_inc == 20'd0) begin
          res.frame_done = 1'b1;
          latch_cnt_d    = '0;
          phase_d        = PhIdle;
        end
      end
      default: ;
    endcase

    res.can_accept = ~pend_valid_d;
  end

  // Control state, updated once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      shift_word_q <= '0;
      bits_left_q  <= '0;
      bit_cycle_q  <= '0;
      cur_last_q   <= 1'b0;
      pend_word_q  <= '0;
      pend_valid_q <= 1'b0;
      pend_last_q  <= 1'b0;
      latch_cnt_q  <= '0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      shift_word_q <= shift_word_d;
      bits_left_q  <= bits_left_d;
      bit_cycle_q  <= bit_cycle_d;
      cur_last_q   <= cur_last_d;
      pend_word_q  <= pend_word_d;
      pend_valid_q <= pend_valid_d;
      pend_last_q  <= pend_last_d;
      latch_cnt_q  <= latch_cnt_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // An underrun and a frame end cannot come from the same tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.underrun && out_data_q.frame_done))
    else $error("underrun and frame_done in one item");

  // Underrun and frame end only occur while the serializer is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.underrun || out_data_q.frame_done))
      |-> out_data_q.busy_res)
    else $error("status pulse without busy");

  // The bit counter never exceeds one pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_left_q <= PixelBits)
    else $error("bits_left out of range");

  // While sending, at least one bit remains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSend) |-> (bits_left_q != 5'd0))
    else $error("sending with no bits left");

  // State only moves on an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(phase_q) && $stable(pend_valid_q))
    else $error("state changed without an item");
`endif

endmodule
